// ----- hdl/sclc_pkg.sv -----
// Shared types, constants and helpers for the source comment line counter.
`default_nettype none
package sclc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_SLASH      = 3'd1,
    PH_LINE_CMT   = 3'd2,
    PH_CODE       = 3'd3,
    PH_BLOCK_CMT  = 3'd4,
    PH_STAR       = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] lines_total;
    logic [OUT_WIDTH-1:0] lines_code;
    logic [OUT_WIDTH-1:0] lines_comment;
    logic [OUT_WIDTH-1:0] bytes_total;
  } out_item_t;

  // Line events raised by the scanner for one byte.
  typedef struct packed {
    logic line_any;
    logic line_code;
    logic line_comment;
  } line_ev_t;

  typedef struct packed {
    count_t total;
    count_t code;
    count_t comment;
    count_t bytes;
  } counts_t;

  // Saturating increment.
  function automatic count_t sat_inc(input count_t v, input logic en);
    count_t r;
    r = v;
    if (en && (v != {COUNT_WIDTH{1'b1}})) begin
      r = v + count_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sclc_scanner.sv -----
// Six-phase byte scanner: classifies each newline as blank, code or comment.
`default_nettype none
module sclc_scanner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_file,
  output sclc_pkg::line_ev_t       ev
);

  sclc_pkg::phase_t phase_r;
  sclc_pkg::phase_t phase_nxt;
  sclc_pkg::phase_t scan_nxt;

  logic is_nl;
  logic is_blank;

  assign is_nl    = (text_byte == sclc_pkg::CH_NL);
  assign is_blank = (text_byte == sclc_pkg::CH_SP) || (text_byte == sclc_pkg::CH_TAB) ||
                    (text_byte == sclc_pkg::CH_CR);

  // Next phase
  always_comb begin
    scan_nxt = phase_r;
    unique case (phase_r)
      sclc_pkg::PH_SLASH: begin
        if (text_byte == sclc_pkg::CH_SLASH)     scan_nxt = sclc_pkg::PH_LINE_CMT;
        else if (text_byte == sclc_pkg::CH_STAR) scan_nxt = sclc_pkg::PH_BLOCK_CMT;
        else if (is_nl)                          scan_nxt = sclc_pkg::PH_LINE_START;
        else                                     scan_nxt = sclc_pkg::PH_CODE;
      end
      sclc_pkg::PH_LINE_CMT, sclc_pkg::PH_CODE: begin
        if (is_nl) scan_nxt = sclc_pkg::PH_LINE_START;
      end
      sclc_pkg::PH_BLOCK_CMT: begin
        if (text_byte == sclc_pkg::CH_STAR) scan_nxt = sclc_pkg::PH_STAR;
      end
      sclc_pkg::PH_STAR: begin
        if (text_byte == sclc_pkg::CH_SLASH)     scan_nxt = sclc_pkg::PH_LINE_START;
        else if (text_byte != sclc_pkg::CH_STAR) scan_nxt = sclc_pkg::PH_BLOCK_CMT;
      end
      default: begin
        // line start; unused codes behave the same
        if (text_byte == sclc_pkg::CH_SLASH) scan_nxt = sclc_pkg::PH_SLASH;
        else if (is_nl || is_blank)          scan_nxt = sclc_pkg::PH_LINE_START;
        else                                 scan_nxt = sclc_pkg::PH_CODE;
      end
    endcase
    phase_nxt = end_of_file ? sclc_pkg::PH_LINE_START : scan_nxt;
  end

  // Line events
  always_comb begin
    ev = '0;
    if (step && is_nl) begin
      ev.line_any = 1'b1;
      unique case (phase_r)
        sclc_pkg::PH_SLASH, sclc_pkg::PH_CODE: ev.line_code = 1'b1;
        sclc_pkg::PH_LINE_CMT, sclc_pkg::PH_BLOCK_CMT,
        sclc_pkg::PH_STAR:                     ev.line_comment = 1'b1;
        default:                               ev.line_code = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sclc_pkg::PH_LINE_START;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sclc_counters.sv -----
// Saturating running totals of lines and bytes.
`default_nettype none
module sclc_counters (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire sclc_pkg::line_ev_t  ev,
  output sclc_pkg::counts_t        cnt_nxt
);

  sclc_pkg::counts_t cnt_r;

  always_comb begin
    cnt_nxt.total   = sclc_pkg::sat_inc(cnt_r.total, ev.line_any);
    cnt_nxt.code    = sclc_pkg::sat_inc(cnt_r.code, ev.line_code);
    cnt_nxt.comment = sclc_pkg::sat_inc(cnt_r.comment, ev.line_comment);
    cnt_nxt.bytes   = sclc_pkg::sat_inc(cnt_r.bytes, step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/source_comment_line_counter.sv -----
// Top level of the source comment line counter.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  sclc_pkg::in_item_t (text_byte, end_of_file)
//   out_     output     out_valid/out_stall sclc_pkg::out_item_t (four totals)
//
// One byte per cycle sustained while no held result stalls an end_of_file byte; the
// flagged byte's totals pass from the input register into the result register.
// Path: input register -> scanner phase update and saturating counter increments
// -> result register. Only a byte flagged end_of_file produces an item.
// A stalled result only holds back a following end_of_file byte; plain bytes keep
// flowing past it into the counters.
// Synchronous active-low reset clears the phase, all totals and both valid flags.
`default_nettype none
module source_comment_line_counter (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sclc_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sclc_pkg::out_item_t       out_item
);

  // input register
  logic                s1_valid_r;
  sclc_pkg::in_item_t  s1_item_r;

  // result register
  logic                out_valid_r;
  sclc_pkg::out_item_t out_item_r;

  logic                out_free;
  logic                s1_go;
  sclc_pkg::line_ev_t  ev;
  sclc_pkg::counts_t   cnt_nxt;
  sclc_pkg::out_item_t result;

  // A byte in the input register moves on unless it needs the result slot and
  // that slot is still held.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_item_r.end_of_file || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  sclc_scanner u_scanner (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_go),
    .text_byte   (s1_item_r.text_byte),
    .end_of_file (s1_item_r.end_of_file),
    .ev          (ev)
  );

  sclc_counters u_counters (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .ev      (ev),
    .cnt_nxt (cnt_nxt)
  );

  // totals include the flagged byte itself
  always_comb begin
    result.lines_total   = sclc_pkg::OUT_WIDTH'(cnt_nxt.total);
    result.lines_code    = sclc_pkg::OUT_WIDTH'(cnt_nxt.code);
    result.lines_comment = sclc_pkg::OUT_WIDTH'(cnt_nxt.comment);
    result.bytes_total   = sclc_pkg::OUT_WIDTH'(cnt_nxt.bytes);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // a new result loads, or a held one stays until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (s1_go && s1_item_r.end_of_file) || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.end_of_file) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ----- hdl/sclc_checker.sv -----
// Port-level checks for the source comment line counter, bound to the top level.
`default_nettype none
module sclc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire sclc_pkg::in_item_t   in_item,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire sclc_pkg::out_item_t  out_item
);

  // stalled byte keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input changed while stalled");

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // code and comment lines never exceed all lines unless the line total has saturated
  a_line_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.lines_total != {sclc_pkg::OUT_WIDTH{1'b1}}) |->
      ({1'b0, out_item.lines_code} + {1'b0, out_item.lines_comment}) <=
      {1'b0, out_item.lines_total})
    else $error("line split exceeds total");

  // every newline is a byte
  a_lines_le_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.lines_total <= out_item.bytes_total)
    else $error("more lines than bytes");

endmodule

bind source_comment_line_counter sclc_checker u_sclc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
